>>> design/lrbs_pkg.sv
// Shared types and constants for the link reconnect backoff supervisor.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package lrbs_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned DELAY_W     = 24;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [1:0] {
      ACT_NONE      = 2'd0,
      ACT_NUDGE     = 2'd1,
      ACT_REINIT    = 2'd2,
      ACT_RECOVERED = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUDGE_BASE    = 3'd0,
      CSR_NUDGE_MAX     = 3'd1,
      CSR_LOSS_GRACE    = 3'd2,
      CSR_REINIT_AFTER  = 3'd3,
      CSR_REINIT_FAILED = 3'd4
   } csr_index_type;

   localparam logic [STATUS_W-1:0] STATUS_CONNECT_FAILED = 3'd4;

   localparam logic CAUSE_OUTAGE = 1'b0;
   localparam logic CAUSE_FAILED = 1'b1;

   localparam logic [DELAY_W-1:0] RESET_NUDGE_BASE    = 24'd1000;
   localparam logic [DELAY_W-1:0] RESET_NUDGE_MAX     = 24'd32000;
   localparam logic [DELAY_W-1:0] RESET_LOSS_GRACE    = 24'd5000;
   localparam logic [DELAY_W-1:0] RESET_REINIT_AFTER  = 24'd300000;
   localparam logic [DELAY_W-1:0] RESET_REINIT_FAILED = 24'd30000;

   typedef struct packed {
      logic [TIME_W-1:0]   now_ms;
      logic                is_connected;
      logic [STATUS_W-1:0] link_status;
   } item_type;

   typedef struct packed {
      action_type         action;
      logic               loss_report;
      logic               reinit_cause;
      logic [DELAY_W-1:0] next_delay_ms;
   } result_type;

   typedef struct packed {
      logic [DELAY_W-1:0] nudge_base_ms;
      logic [DELAY_W-1:0] nudge_max_ms;
      logic [DELAY_W-1:0] loss_grace_ms;
      logic [DELAY_W-1:0] reinit_after_ms;
      logic [DELAY_W-1:0] reinit_failed_ms;
   } cfg_type;

   typedef struct packed {
      logic                in_outage;
      logic [TIME_W-1:0]   outage_start;
      logic [TIME_W-1:0]   last_nudge_time;
      logic [DELAY_W-1:0]  nudge_delay;
      logic [STATUS_W-1:0] prev_status;
      logic                failed_active;
      logic [TIME_W-1:0]   failed_start;
      logic                loss_sent;
   } state_type;

endpackage

`default_nettype wire

>>> design/lrbs_if.sv
// Valid/ready channel interfaces for poll beats and result beats.
// Depends on lrbs_pkg for the field widths and the action code type.
`default_nettype none

interface lrbs_req_if;
   logic                          valid;
   logic                          ready;
   logic [lrbs_pkg::TIME_W-1:0]   now_ms;
   logic                          is_connected;
   logic [lrbs_pkg::STATUS_W-1:0] link_status;

   modport source (output valid, output now_ms, output is_connected, output link_status,
                   input ready);
   modport sink   (input valid, input now_ms, input is_connected, input link_status,
                   output ready);
endinterface

interface lrbs_rsp_if;
   logic                         valid;
   logic                         ready;
   lrbs_pkg::action_type         action;
   logic                         loss_report;
   logic                         reinit_cause;
   logic [lrbs_pkg::DELAY_W-1:0] next_delay_ms;

   modport source (output valid, output action, output loss_report, output reinit_cause,
                   output next_delay_ms, input ready);
   modport sink   (input valid, input action, input loss_report, input reinit_cause,
                   input next_delay_ms, output ready);
endinterface

`default_nettype wire

>>> design/lrbs_csr.sv
// Configuration register file of the supervisor: five 24-bit timing settings.
// Depends on lrbs_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module lrbs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lrbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrbs_pkg::DELAY_W-1:0]        csr_wdata,
   output lrbs_pkg::cfg_type                   cfg
);

   lrbs_pkg::cfg_type cfg_ff;
   lrbs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lrbs_pkg::CSR_NUDGE_BASE:    cfg_in.nudge_base_ms    = csr_wdata;
            lrbs_pkg::CSR_NUDGE_MAX:     cfg_in.nudge_max_ms     = csr_wdata;
            lrbs_pkg::CSR_LOSS_GRACE:    cfg_in.loss_grace_ms    = csr_wdata;
            lrbs_pkg::CSR_REINIT_AFTER:  cfg_in.reinit_after_ms  = csr_wdata;
            lrbs_pkg::CSR_REINIT_FAILED: cfg_in.reinit_failed_ms = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nudge_base_ms    <= lrbs_pkg::RESET_NUDGE_BASE;
         cfg_ff.nudge_max_ms     <= lrbs_pkg::RESET_NUDGE_MAX;
         cfg_ff.loss_grace_ms    <= lrbs_pkg::RESET_LOSS_GRACE;
         cfg_ff.reinit_after_ms  <= lrbs_pkg::RESET_REINIT_AFTER;
         cfg_ff.reinit_failed_ms <= lrbs_pkg::RESET_REINIT_FAILED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> design/lrbs_step.sv
// Combinational evaluation of one poll against the outage episode state.
// Depends on lrbs_pkg for the item, result, state and configuration types.
`default_nettype none

module lrbs_step (
   input  lrbs_pkg::cfg_type    cfg,
   input  lrbs_pkg::state_type  state,
   input  lrbs_pkg::item_type   item,
   output lrbs_pkg::state_type  state_next,
   output lrbs_pkg::result_type result
);

   localparam int unsigned PAD_W = lrbs_pkg::TIME_W - lrbs_pkg::DELAY_W;

   // Episode state as seen by this poll, after a possible fresh start.
   logic                                fresh;
   logic [lrbs_pkg::TIME_W-1:0]         ep_start;
   logic [lrbs_pkg::TIME_W-1:0]         ep_last_nudge;
   logic [lrbs_pkg::DELAY_W-1:0]        ep_delay;
   logic [lrbs_pkg::STATUS_W-1:0]       ep_prev;
   logic                                ep_failed;
   logic [lrbs_pkg::TIME_W-1:0]         ep_failed_start;
   logic                                ep_loss_sent;

   logic [lrbs_pkg::TIME_W-1:0]         outage_age;
   logic [lrbs_pkg::TIME_W-1:0]         nudge_age;
   logic [lrbs_pkg::TIME_W-1:0]         failed_age;
   logic                                loss_now;
   logic                                status_change;
   logic [lrbs_pkg::DELAY_W-1:0]        delay_cur;
   logic                                failed_run;
   logic [lrbs_pkg::TIME_W-1:0]         failed_from;
   logic                                failed_long;
   logic                                reinit;
   logic                                nudge;
   logic [lrbs_pkg::DELAY_W:0]          delay_dbl;
   logic [lrbs_pkg::DELAY_W-1:0]        delay_grown;

   always_comb begin
      fresh           = !state.in_outage;
      ep_start        = fresh ? item.now_ms : state.outage_start;
      ep_last_nudge   = fresh ? item.now_ms : state.last_nudge_time;
      ep_delay        = fresh ? cfg.nudge_base_ms : state.nudge_delay;
      ep_prev         = fresh ? item.link_status : state.prev_status;
      ep_failed       = fresh ? 1'b0 : state.failed_active;
      ep_failed_start = fresh ? '0 : state.failed_start;
      ep_loss_sent    = fresh ? 1'b0 : state.loss_sent;

      outage_age    = item.now_ms - ep_start;
      loss_now      = !ep_loss_sent && (outage_age >= {{PAD_W{1'b0}}, cfg.loss_grace_ms});
      status_change = item.link_status != ep_prev;
      delay_cur     = status_change ? cfg.nudge_base_ms : ep_delay;

      // The failed timer runs only while the status stays at connect-failed.
      failed_run  = item.link_status == lrbs_pkg::STATUS_CONNECT_FAILED;
      failed_from = (failed_run && !ep_failed) ? item.now_ms : ep_failed_start;
      failed_age  = item.now_ms - failed_from;
      failed_long = failed_run && (failed_age >= {{PAD_W{1'b0}}, cfg.reinit_failed_ms});

      reinit    = failed_long || (outage_age >= {{PAD_W{1'b0}}, cfg.reinit_after_ms});
      nudge_age = item.now_ms - ep_last_nudge;
      nudge     = !reinit && (status_change || nudge_age >= {{PAD_W{1'b0}}, delay_cur});

      delay_dbl = {delay_cur, 1'b0};
      if (delay_cur >= cfg.nudge_max_ms) begin
         delay_grown = delay_cur;
      end else if (delay_dbl < {1'b0, cfg.nudge_max_ms}) begin
         delay_grown = delay_dbl[lrbs_pkg::DELAY_W-1:0];
      end else begin
         delay_grown = cfg.nudge_max_ms;
      end

      state_next = state;
      result     = '{action: lrbs_pkg::ACT_NONE, loss_report: 1'b0,
                     reinit_cause: lrbs_pkg::CAUSE_OUTAGE,
                     next_delay_ms: state.nudge_delay};

      if (item.is_connected) begin
         if (state.in_outage) begin
            state_next.in_outage = 1'b0;
            result.action        = lrbs_pkg::ACT_RECOVERED;
         end
      end else begin
         state_next.in_outage       = 1'b1;
         state_next.prev_status     = item.link_status;
         state_next.failed_start    = failed_from;
         state_next.failed_active   = failed_run && !reinit;
         state_next.loss_sent       = ep_loss_sent || loss_now;
         state_next.outage_start    = reinit ? item.now_ms : ep_start;
         result.loss_report         = loss_now;
         if (reinit) begin
            state_next.last_nudge_time = item.now_ms;
            state_next.nudge_delay     = cfg.nudge_base_ms;
            result.action              = lrbs_pkg::ACT_REINIT;
            result.reinit_cause        = failed_long ? lrbs_pkg::CAUSE_FAILED
                                                     : lrbs_pkg::CAUSE_OUTAGE;
         end else if (nudge) begin
            state_next.last_nudge_time = item.now_ms;
            state_next.nudge_delay     = delay_grown;
            result.action              = lrbs_pkg::ACT_NUDGE;
         end else begin
            state_next.last_nudge_time = ep_last_nudge;
            state_next.nudge_delay     = delay_cur;
         end
         result.next_delay_ms = state_next.nudge_delay;
      end
   end

endmodule

`default_nettype wire

>>> design/link_reconnect_backoff_supervisor.sv
// Link reconnect supervisor with exponential nudge backoff and re-init timers.
// An accepted poll beat passes through the input register, then the episode
// evaluation into the result register, before its result beat.
// Throughput: one poll per cycle unless the result side stalls; the episode state is updated as each result loads.
// Reset (synchronous, active high) closes any outage, clears both stages and
// restores the five timing settings to their defaults.
`default_nettype none

module link_reconnect_backoff_supervisor (
   input  logic                              clock,
   input  logic                              reset,
   lrbs_req_if.sink                          req_chan,
   lrbs_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [lrbs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lrbs_pkg::DELAY_W-1:0]      csr_wdata
);

   lrbs_pkg::cfg_type    cfg;
   lrbs_pkg::state_type  state_ff;
   lrbs_pkg::state_type  state_in;
   lrbs_pkg::state_type  step_state;
   lrbs_pkg::result_type step_result;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   lrbs_pkg::item_type   s1_item_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   lrbs_pkg::result_type out_data_ff;
   logic                 req_take;
   logic                 advance;

   lrbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lrbs_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (s1_item_ff),
      .state_next (step_state),
      .result     (step_result)
   );

   // The held poll moves on when the result register is empty or being drained.
   assign advance          = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !s1_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      state_in     = advance ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff                <= 1'b0;
         out_valid_ff               <= 1'b0;
         state_ff.in_outage         <= 1'b0;
         state_ff.outage_start      <= '0;
         state_ff.last_nudge_time   <= '0;
         state_ff.nudge_delay       <= lrbs_pkg::RESET_NUDGE_BASE;
         state_ff.prev_status       <= '0;
         state_ff.failed_active     <= 1'b0;
         state_ff.failed_start      <= '0;
         state_ff.loss_sent         <= 1'b0;
      end else begin
         s1_valid_ff              <= s1_valid_in;
         out_valid_ff             <= out_valid_in;
         state_ff                 <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.now_ms       <= req_chan.now_ms;
         s1_item_ff.is_connected <= req_chan.is_connected;
         s1_item_ff.link_status  <= req_chan.link_status;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.action        = out_data_ff.action;
   assign rsp_chan.loss_report   = out_data_ff.loss_report;
   assign rsp_chan.reinit_cause  = out_data_ff.reinit_cause;
   assign rsp_chan.next_delay_ms = out_data_ff.next_delay_ms;

`ifndef SYNTH
   // A re-init always restarts the backoff from the configured base delay.
   a_reinit_base : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.action == lrbs_pkg::ACT_REINIT)
         |-> (rsp_chan.next_delay_ms == cfg.nudge_base_ms))
      else $error("re-init beat without base delay");

   // The connect-failed cause is only ever reported with a re-init.
   a_cause_only_reinit : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.reinit_cause)
         |-> (rsp_chan.action == lrbs_pkg::ACT_REINIT))
      else $error("re-init cause on a beat that is not a re-init");

   // An outage closes only together with a recovered result beat.
   a_close_recovered : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(state_ff.in_outage))
         |-> (out_valid_ff && out_data_ff.action == lrbs_pkg::ACT_RECOVERED))
      else $error("outage closed without a recovered beat");

   // The loss report belongs to a poll taken while the link is down.
   a_loss_in_outage : assert property (@(posedge clock) disable iff (reset)
      (advance && step_result.loss_report) |=> state_ff.in_outage)
      else $error("loss report outside an outage");
`endif

endmodule

`default_nettype wire

>>> tb/lrbs_supervisor_checker.sv
// Result checker for the link reconnect backoff supervisor: watches the poll, result and
// register-write ports, predicts each result beat and compares it field by field.
// Depends on lrbs_pkg and the lrbs_req_if / lrbs_rsp_if channel interfaces.
`timescale 1ns / 100ps

module lrbs_supervisor_checker (
   input  logic                             clock,
   input  logic                             reset,
   lrbs_req_if                              req_mon,
   lrbs_rsp_if                              rsp_mon,
   input  logic                             csr_we,
   input  logic [lrbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lrbs_pkg::DELAY_W-1:0]     csr_wdata,
   output int                               mismatch_count,
   output int                               beats_in_flight,
   output int                               results_checked,
   output int                               nudges_seen,
   output int                               reinits_seen,
   output int                               losses_seen,
   output int                               recoveries_seen
);
   import lrbs_pkg::*;

   cfg_type    timers;
   state_type  episode;
   result_type expected_results[$];

   int mismatches;
   int checked;
   int nudges;
   int reinits;
   int losses;
   int recoveries;

   // Advances the outage episode by one poll and returns the result it should produce.
   function automatic result_type evaluate_poll(input item_type poll);
      result_type        r;
      logic              forced;
      logic              failed_long;
      logic [TIME_W-1:0] outage_age;
      logic [TIME_W-1:0] failed_age;
      logic [TIME_W-1:0] nudge_age;
      logic [DELAY_W:0]  doubled;
      r = '0;
      r.action = ACT_NONE;
      r.reinit_cause = CAUSE_OUTAGE;
      forced = 1'b0;
      if (poll.is_connected) begin
         if (episode.in_outage) begin
            episode.in_outage = 1'b0;
            r.action = ACT_RECOVERED;
         end
      end else begin
         if (!episode.in_outage) begin
            episode.in_outage = 1'b1;
            episode.outage_start = poll.now_ms;
            episode.last_nudge_time = poll.now_ms;
            episode.nudge_delay = timers.nudge_base_ms;
            episode.prev_status = poll.link_status;
            episode.failed_active = 1'b0;
            episode.failed_start = '0;
            episode.loss_sent = 1'b0;
         end
         outage_age = poll.now_ms - episode.outage_start;
         if (!episode.loss_sent && outage_age >= timers.loss_grace_ms) begin
            episode.loss_sent = 1'b1;
            r.loss_report = 1'b1;
         end
         if (poll.link_status != episode.prev_status) begin
            episode.prev_status = poll.link_status;
            episode.nudge_delay = timers.nudge_base_ms;
            forced = 1'b1;
         end
         if (poll.link_status == STATUS_CONNECT_FAILED) begin
            if (!episode.failed_active) begin
               episode.failed_active = 1'b1;
               episode.failed_start = poll.now_ms;
            end
         end else begin
            episode.failed_active = 1'b0;
         end
         failed_age = poll.now_ms - episode.failed_start;
         failed_long = episode.failed_active && (failed_age >= timers.reinit_failed_ms);
         nudge_age = poll.now_ms - episode.last_nudge_time;
         // A re-init restarts the episode except the loss report and suppresses any nudge.
         if (failed_long || outage_age >= timers.reinit_after_ms) begin
            r.action = ACT_REINIT;
            r.reinit_cause = failed_long ? CAUSE_FAILED : CAUSE_OUTAGE;
            episode.outage_start = poll.now_ms;
            episode.last_nudge_time = poll.now_ms;
            episode.nudge_delay = timers.nudge_base_ms;
            episode.failed_active = 1'b0;
            episode.prev_status = poll.link_status;
         end else if (forced || nudge_age >= episode.nudge_delay) begin
            r.action = ACT_NUDGE;
            episode.last_nudge_time = poll.now_ms;
            if (episode.nudge_delay < timers.nudge_max_ms) begin
               doubled = {episode.nudge_delay, 1'b0};
               episode.nudge_delay = (doubled < timers.nudge_max_ms) ?
                                     doubled[DELAY_W-1:0] : timers.nudge_max_ms;
            end
         end
      end
      r.next_delay_ms = episode.nudge_delay;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      item_type   poll;
      result_type want;
      result_type got;
      if (reset) begin
         timers.nudge_base_ms = RESET_NUDGE_BASE;
         timers.nudge_max_ms = RESET_NUDGE_MAX;
         timers.loss_grace_ms = RESET_LOSS_GRACE;
         timers.reinit_after_ms = RESET_REINIT_AFTER;
         timers.reinit_failed_ms = RESET_REINIT_FAILED;
         episode = '0;
         episode.nudge_delay = RESET_NUDGE_BASE;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUDGE_BASE:    timers.nudge_base_ms = csr_wdata;
               CSR_NUDGE_MAX:     timers.nudge_max_ms = csr_wdata;
               CSR_LOSS_GRACE:    timers.loss_grace_ms = csr_wdata;
               CSR_REINIT_AFTER:  timers.reinit_after_ms = csr_wdata;
               CSR_REINIT_FAILED: timers.reinit_failed_ms = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            poll.now_ms = req_mon.now_ms;
            poll.is_connected = req_mon.is_connected;
            poll.link_status = req_mon.link_status;
            expected_results.push_back(evaluate_poll(poll));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.action = rsp_mon.action;
            got.loss_report = rsp_mon.loss_report;
            got.reinit_cause = rsp_mon.reinit_cause;
            got.next_delay_ms = rsp_mon.next_delay_ms;
            if (expected_results.size() == 0) begin
               $error("result beat with no poll awaiting it: action %0d, delay %0d",
                      got.action, got.next_delay_ms);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (got.action !== want.action) begin
                  $error("action: expected %0d, got %0d", want.action, got.action);
                  mismatches++;
               end
               if (got.loss_report !== want.loss_report) begin
                  $error("loss_report: expected %0d, got %0d",
                         want.loss_report, got.loss_report);
                  mismatches++;
               end
               if (got.reinit_cause !== want.reinit_cause) begin
                  $error("reinit_cause: expected %0d, got %0d",
                         want.reinit_cause, got.reinit_cause);
                  mismatches++;
               end
               if (got.next_delay_ms !== want.next_delay_ms) begin
                  $error("next_delay_ms: expected %0d, got %0d",
                         want.next_delay_ms, got.next_delay_ms);
                  mismatches++;
               end
               case (want.action)
                  ACT_NUDGE:     nudges++;
                  ACT_REINIT:    reinits++;
                  ACT_RECOVERED: recoveries++;
                  default: ;
               endcase
               if (want.loss_report) losses++;
            end
         end
      end
      mismatch_count <= mismatches;
      beats_in_flight <= expected_results.size();
      results_checked <= checked;
      nudges_seen <= nudges;
      reinits_seen <= reinits;
      losses_seen <= losses;
      recoveries_seen <= recoveries;
   end

endmodule

>>> tb/link_reconnect_backoff_supervisor_tb.sv
// Top of the link reconnect backoff supervisor testbench: clock, reset, poll stimulus,
// timer register settings and result back-pressure; lrbs_supervisor_checker does the checking.
// Depends on lrbs_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 100ps

module link_reconnect_backoff_supervisor_tb;
   import lrbs_pkg::*;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int HOLD_CYCLES   = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int CSR_SPARE_LO  = 5;
   localparam int CSR_SPARE_HI  = 7;

   localparam logic [STATUS_W-1:0] ST_IDLE         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_NET       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SCAN_DONE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CONNECTED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOST         = 3'd5;
   localparam logic [STATUS_W-1:0] ST_DISCONNECTED = 3'd6;
   localparam logic [STATUS_W-1:0] ST_OTHER        = 3'd7;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DELAY_W-1:0]     csr_wdata;

   logic hold_rsp = 1'b0;
   logic calm = 1'b0;
   logic [TIME_W-1:0] t_ms = '0;
   int   polls_sent = 0;
   int   settings_used = 0;
   int   cycle_count = 0;

   int mismatch_count;
   int beats_in_flight;
   int results_checked;
   int nudges_seen;
   int reinits_seen;
   int losses_seen;
   int recoveries_seen;

   lrbs_req_if req_if ();
   lrbs_rsp_if rsp_if ();

   link_reconnect_backoff_supervisor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lrbs_supervisor_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .beats_in_flight (beats_in_flight),
      .results_checked (results_checked),
      .nudges_seen     (nudges_seen),
      .reinits_seen    (reinits_seen),
      .losses_seen     (losses_seen),
      .recoveries_seen (recoveries_seen)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d result beats outstanding.",
                  cycle_count, beats_in_flight);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Mostly no gap, sometimes a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [STATUS_W-1:0] pick_status();
      if ($urandom_range(0, 99) < 35) return STATUS_CONNECT_FAILED;
      return STATUS_W'($urandom_range(0, 7));
   endfunction

   function automatic logic [TIME_W-1:0] next_step(input int unsigned step_hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return $urandom_range(0, step_hi / 8);
      if (r < 85) return $urandom_range(0, step_hi);
      if (r < 97) return $urandom_range(step_hi, step_hi * 4);
      return $urandom;
   endfunction

   function automatic cfg_type timers_of(input logic [DELAY_W-1:0] base,
                                         input logic [DELAY_W-1:0] cap,
                                         input logic [DELAY_W-1:0] grace,
                                         input logic [DELAY_W-1:0] after,
                                         input logic [DELAY_W-1:0] failed);
      cfg_type c;
      c.nudge_base_ms = base;
      c.nudge_max_ms = cap;
      c.loss_grace_ms = grace;
      c.reinit_after_ms = after;
      c.reinit_failed_ms = failed;
      return c;
   endfunction

   // Offers one poll beat, after a random gap, and returns at the edge that accepts it.
   task automatic send_poll(input logic [TIME_W-1:0] now, input logic conn,
                            input logic [STATUS_W-1:0] st);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.now_ms <= now;
      req_if.is_connected <= conn;
      req_if.link_status <= st;
      do @(posedge clock); while (!req_if.ready);
      polls_sent++;
   endtask

   // Stops offering and waits until every accepted poll has had its result beat.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (beats_in_flight != 0) @(posedge clock);
   endtask

   // The caller lowers csr_we once its run of writes is over.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DELAY_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_timers(input cfg_type c);
      write_reg(CSR_NUDGE_BASE, c.nudge_base_ms);
      write_reg(CSR_NUDGE_MAX, c.nudge_max_ms);
      write_reg(CSR_LOSS_GRACE, c.loss_grace_ms);
      write_reg(CSR_REINIT_AFTER, c.reinit_after_ms);
      write_reg(CSR_REINIT_FAILED, c.reinit_failed_ms);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_directed();
      int idx;
      // Timers at their reset values: 1 s base, 32 s cap, 5 s grace, 300 s and 30 s re-init.
      send_poll(32'h0000_0000, 1'b1, ST_CONNECTED);
      t_ms = 32'hFFFF_F000;
      send_poll(t_ms, 1'b0, ST_DISCONNECTED);
      t_ms += 1000;   send_poll(t_ms, 1'b0, ST_DISCONNECTED);
      // The timestamp wraps here, and the grace period runs out on the same poll.
      t_ms += 5000;   send_poll(t_ms, 1'b0, ST_DISCONNECTED);
      t_ms += 100;    send_poll(t_ms, 1'b0, ST_NO_NET);
      t_ms += 100;    send_poll(t_ms, 1'b0, STATUS_CONNECT_FAILED);
      t_ms += 10000;  send_poll(t_ms, 1'b0, STATUS_CONNECT_FAILED);
      t_ms += 20000;  send_poll(t_ms, 1'b0, STATUS_CONNECT_FAILED);
      t_ms += 100;    send_poll(t_ms, 1'b0, ST_SCAN_DONE);
      // A status change and an outage that is too long together: the re-init must win.
      t_ms += 300000; send_poll(t_ms, 1'b0, ST_OTHER);
      t_ms += 1;      send_poll(t_ms, 1'b0, ST_OTHER);
      send_poll(32'hFFFF_FFFF, 1'b0, ST_IDLE);
      send_poll(32'hFFFF_FFFF, 1'b1, ST_LOST);
      send_poll(32'hFFFF_FFFF, 1'b1, ST_IDLE);

      // Writes to the unused register indexes must leave the timers alone.
      wait_idle();
      for (idx = CSR_SPARE_LO; idx <= CSR_SPARE_HI; idx++) write_reg(idx[2:0], '1);
      csr_we <= 1'b0;
      t_ms = 32'd1000;
      send_poll(t_ms, 1'b0, ST_LOST);
      t_ms += 1000;   send_poll(t_ms, 1'b0, ST_LOST);
      send_poll(t_ms, 1'b1, ST_CONNECTED);

      // Base above the cap: the delay never doubles. Zero grace and zero failed limit.
      wait_idle();
      load_timers(timers_of(24'd3000, 24'd100, 24'd0, 24'hFF_FFFF, 24'd0));
      send_poll(t_ms, 1'b0, STATUS_CONNECT_FAILED);
      t_ms += 10;     send_poll(t_ms, 1'b0, ST_LOST);
      t_ms += 3000;   send_poll(t_ms, 1'b0, ST_LOST);
      send_poll(t_ms, 1'b1, ST_CONNECTED);
   endtask

   // Mostly whole outage episodes with random content, with some stray polls mixed in.
   task automatic run_phase(input cfg_type c, input int unsigned step_hi, input int quota);
      int sent_here;
      int n;
      int k;
      logic [STATUS_W-1:0] st;
      wait_idle();
      load_timers(c);
      sent_here = 0;
      while (sent_here < quota) begin
         if ($urandom_range(0, 9) == 0) begin
            send_poll($urandom, 1'($urandom_range(0, 1)), STATUS_W'($urandom_range(0, 7)));
            sent_here++;
         end else begin
            repeat ($urandom_range(0, 2)) begin
               t_ms += next_step(step_hi);
               send_poll(t_ms, 1'b1, STATUS_W'($urandom_range(0, 7)));
               sent_here++;
            end
            n = $urandom_range(2, 30);
            st = pick_status();
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 5) == 0) st = pick_status();
               t_ms += next_step(step_hi);
               send_poll(t_ms, 1'b0, st);
            end
            sent_here += n;
            t_ms += next_step(step_hi);
            send_poll(t_ms, 1'b1, STATUS_W'($urandom_range(0, 7)));
            sent_here++;
         end
      end
   endtask

   initial begin : result_drain
      int stall;
      int sent_mark;
      forever begin
         if (hold_rsp) begin
            // The hold starts only once the sender has had a poll accepted again.
            rsp_if.ready <= 1'b1;
            sent_mark = polls_sent;
            while (polls_sent == sent_mark) @(posedge clock);
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
            stall = pick_gap();
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.now_ms <= '0;
      req_if.is_connected <= 1'b0;
      req_if.link_status <= ST_IDLE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      run_phase(timers_of(24'd1000, 24'd32000, 24'd5000, 24'd300000, 24'd30000), 8000, 190);
      run_phase(timers_of(24'd0, 24'd0, 24'd0, 24'd0, 24'd0), 10, 190);
      run_phase(timers_of('1, '1, '1, '1, '1), 32'h40_0000, 190);
      run_phase(timers_of(24'd0, '1, 24'd50, 24'd5000, 24'd800), 300, 190);
      run_phase(timers_of(24'd700, 24'd300, 24'd2000, 24'd40000, 24'd6000), 1500, 190);
      run_phase(timers_of(24'd1, '1, 24'd100000, '1, 24'd200000), 32'h1_0000, 190);
      run_phase(timers_of(DELAY_W'($urandom_range(1, 5000)),
                          DELAY_W'($urandom_range(0, 100000)),
                          DELAY_W'($urandom_range(0, 20000)),
                          DELAY_W'($urandom_range(0, 400000)),
                          DELAY_W'($urandom_range(0, 60000))), 10000, 190);

      // Back-to-back polls while the result side holds off, so the block backs up.
      calm = 1'b1;
      hold_rsp = 1'b1;
      run_phase(timers_of(DELAY_W'($urandom_range(1, 5000)),
                          DELAY_W'($urandom_range(0, 100000)),
                          DELAY_W'($urandom_range(0, 20000)),
                          DELAY_W'($urandom_range(0, 400000)),
                          DELAY_W'($urandom_range(0, 60000))), 10000, 80);
      calm = 1'b0;
      run_phase(timers_of(DELAY_W'($urandom_range(0, 2000)),
                          DELAY_W'($urandom_range(0, 50000)),
                          DELAY_W'($urandom_range(0, 10000)),
                          DELAY_W'($urandom_range(0, 200000)),
                          DELAY_W'($urandom_range(0, 30000))), 6000, 110);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d polls under %0d timer settings; %0d result beats checked.",
               polls_sent, settings_used, results_checked);
      $display("Seen: %0d nudges, %0d re-inits, %0d loss reports, %0d recoveries.",
               nudges_seen, reinits_seen, losses_seen, recoveries_seen);
      if (mismatch_count == 0 && beats_in_flight == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
